// ===== hw/rtl/isr_pkg.sv =====
package isr_pkg;

	// Default number of root bits; the radicand operand is twice as wide.
	localparam int unsigned ROOT_WIDTH_DEF = 64;

	// Fixed widths of the port fields.
	localparam int unsigned HALF_W = 64;
	localparam int unsigned OUT_W  = 64;

	// Trial divisor low bits: partial root * 4 + 1.
	localparam logic [1:0] TRIAL_LSB = 2'b01;

endpackage

// ===== hw/rtl/integer_square_root_128.sv =====
// Floor square root of a 128-bit radicand, one root bit per pipeline stage.
// Throughput: one word per cycle while out_ready is high; each stage holds one
// word and a stall backs up only as far as the next empty stage, so bubbles are
// squeezed out.
// Reset: arst_n clears all stage valid bits asynchronously; data is not reset.
module integer_square_root_128 #(
	parameter int unsigned ROOT_WIDTH = isr_pkg::ROOT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [isr_pkg::HALF_W-1:0]  radicand_high,
	input  logic [isr_pkg::HALF_W-1:0]  radicand_low,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [isr_pkg::OUT_W-1:0]   root
);

	localparam int unsigned RAD_W = 2 * ROOT_WIDTH;

	logic                  v_w    [ROOT_WIDTH+1];
	logic                  rdy_w  [ROOT_WIDTH+1];
	logic [ROOT_WIDTH:0]   rem_w  [ROOT_WIDTH+1];
	logic [ROOT_WIDTH-1:0] root_w [ROOT_WIDTH+1];
	logic [RAD_W-1:0]      rad_w  [ROOT_WIDTH+1];

	logic [2*isr_pkg::HALF_W-1:0] radicand;

	assign radicand  = {radicand_high, radicand_low};

	// take only the low 2*ROOT_WIDTH bits as the operand
	assign v_w[0]    = in_valid;
	assign in_ready  = rdy_w[0];
	assign rem_w[0]  = '0;
	assign root_w[0] = '0;
	assign rad_w[0]  = radicand[RAD_W-1:0];

	for (genvar i = 0; i < ROOT_WIDTH; i++) begin : g_stage
		isr_stage #(
			.ROOT_WIDTH(ROOT_WIDTH)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_w[i]),
			.in_ready  (rdy_w[i]),
			.in_rem    (rem_w[i]),
			.in_root   (root_w[i]),
			.in_rad    (rad_w[i]),
			.out_valid (v_w[i+1]),
			.out_ready (rdy_w[i+1]),
			.out_rem   (rem_w[i+1]),
			.out_root  (root_w[i+1]),
			.out_rad   (rad_w[i+1])
		);
	end

	assign rdy_w[ROOT_WIDTH] = out_ready;
	assign out_valid         = v_w[ROOT_WIDTH];
	assign root = isr_pkg::OUT_W'(root_w[ROOT_WIDTH]);

endmodule

// ===== hw/rtl/isr_stage.sv =====
module isr_stage #(
	parameter int unsigned ROOT_WIDTH = isr_pkg::ROOT_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [ROOT_WIDTH:0]       in_rem,
	input  logic [ROOT_WIDTH-1:0]     in_root,
	input  logic [2*ROOT_WIDTH-1:0]   in_rad,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [ROOT_WIDTH:0]       out_rem,
	output logic [ROOT_WIDTH-1:0]     out_root,
	output logic [2*ROOT_WIDTH-1:0]   out_rad
);

	localparam int unsigned CUR_W = ROOT_WIDTH + 3;

	logic                    valid_s1;
	logic [ROOT_WIDTH:0]     rem_s1;
	logic [ROOT_WIDTH-1:0]   root_s1;
	logic [2*ROOT_WIDTH-1:0] rad_s1;

	logic [CUR_W-1:0] cur;
	logic [CUR_W-1:0] trial;
	logic [CUR_W-1:0] diff;
	logic             ge;
	logic [ROOT_WIDTH:0] rem_next;

	// bring down the next two radicand bits and try partial root * 4 + 1
	always_comb begin
		cur      = {in_rem, in_rad[2*ROOT_WIDTH-1 -: 2]};
		trial    = {1'b0, in_root, isr_pkg::TRIAL_LSB};
		ge       = (cur >= trial);
		diff     = cur - trial;
		rem_next = ge ? diff[ROOT_WIDTH:0] : cur[ROOT_WIDTH:0];
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rem_s1  <= rem_next;
			root_s1 <= {in_root[ROOT_WIDTH-2:0], ge};
			rad_s1  <= {in_rad[2*ROOT_WIDTH-3:0], 2'b00};
		end
	end

	assign out_valid = valid_s1;
	assign out_rem   = rem_s1;
	assign out_root  = root_s1;
	assign out_rad   = rad_s1;

endmodule

// ===== hw/rtl/isr_checker.sv =====
module isr_checker #(
	parameter int unsigned ROOT_WIDTH = isr_pkg::ROOT_WIDTH_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [isr_pkg::OUT_W-1:0]  root
);

	localparam int unsigned CNT_W = $clog2(ROOT_WIDTH + 1) + 1;

	logic [CNT_W-1:0] inflight_q;
	logic             in_acc;
	logic             out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// track words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + CNT_W'(1);
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - CNT_W'(1);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(root))
		else $error("result word changed or dropped while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result word without an accepted radicand");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(ROOT_WIDTH))
		else $error("more words in flight than pipeline stages");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output stage");

	a_narrow_root: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (root >> ROOT_WIDTH) == '0)
		else $error("root bits set above the configured root width");

endmodule

bind integer_square_root_128 isr_checker #(
	.ROOT_WIDTH(ROOT_WIDTH)
) u_isr_checker (.*);
